@@ src/ssf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and constants of the state-space filter step
// Field widths, register indexes, command codes and lane control bundle.
// ----------------------------------------------------------------------------
package ssf_pkg;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int CIDX_W    = 5;
    localparam int CFG_IDX_W = 3;

    // Largest configuration the coefficient layout supports
    localparam int MAX_STATES = 4;
    localparam int MAX_INPUTS = 2;
    localparam int G_BASE     = 16;
    localparam int COEF_DEPTH = 24;

    // Bank address wide enough for MAX_STATES + MAX_INPUTS terms
    localparam int TERM_AW = 3;

    // Full-width sum of up to six 64-bit products
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 3;

    // Stream payload widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 136;

    // Commands carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_B   = 3'd4;

    // Per-term control broadcast from the sequencer to every lane
    typedef struct packed {
        logic               issue;
        logic               first;
        logic               last;
        logic [TERM_AW-1:0] addr;
    } t_lane_ctl;

    // Coefficient write shared by all lanes; each lane has its own enable
    typedef struct packed {
        logic [TERM_AW-1:0] addr;
        logic [DATA_W-1:0]  data;
    } t_bank_wr;

endpackage

@@ src/ssf_lane.sv @@
// ----------------------------------------------------------------------------
// ssf_lane: one state element of the filter
// Holds one row of F and G in a small bank and walks it with a
// registered multiply-accumulate, one term per cycle.
// ----------------------------------------------------------------------------
module ssf_lane #(
    parameter int TERMS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  ssf_pkg::t_bank_wr             i_wr,
    input  ssf_pkg::t_lane_ctl            i_ctl,
    input  logic signed [ssf_pkg::DATA_W-1:0] i_opnd,
    output logic signed [ssf_pkg::ACC_W-1:0]  o_acc,
    output logic                          o_done
);
    import ssf_pkg::*;

    localparam int AW = $clog2(TERMS);

    logic [DATA_W-1:0]        r_bank [TERMS];
    logic signed [DATA_W-1:0] r_coef;
    logic signed [DATA_W-1:0] r_opnd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_v1, r_first1, r_last1;
    logic                     r_v2, r_first2, r_last2;
    logic                     r_done;
    logic signed [ACC_W-1:0]  n_acc;

    // Coefficient bank: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_bank[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_ctl.issue) begin
            r_coef <= signed'(r_bank[i_ctl.addr[AW-1:0]]);
            r_opnd <= i_opnd;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= r_coef * r_opnd;
    end

    // Accumulate: first term restarts the sum
    always_comb begin
        n_acc = (r_first2 ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc <= n_acc;
        end
    end

    // Control pipeline alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_first1 <= 1'b0;
            r_last1  <= 1'b0;
            r_v2     <= 1'b0;
            r_first2 <= 1'b0;
            r_last2  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_v1     <= i_ctl.issue;
            r_first1 <= i_ctl.first;
            r_last1  <= i_ctl.last;
            r_v2     <= r_v1;
            r_first2 <= r_first1;
            r_last2  <= r_last1;
            r_done   <= r_v2 && r_last2;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

@@ src/ssf_merge.sv @@
// ----------------------------------------------------------------------------
// ssf_merge: combine the lane sums into the next state vector
// Floors each sum by the fractional width and saturates it to 32 bits.
// ----------------------------------------------------------------------------
module ssf_merge #(
    parameter int NUM_STATES = 4,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [ssf_pkg::ACC_W-1:0]   i_acc [NUM_STATES],
    input  logic [NUM_STATES-1:0]              i_done,
    output logic signed [ssf_pkg::DATA_W-1:0]  o_next [NUM_STATES],
    output logic                               o_valid
);
    import ssf_pkg::*;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [ACC_W-1:0]  w_shift [NUM_STATES];
    logic signed [DATA_W-1:0] n_next  [NUM_STATES];
    logic signed [DATA_W-1:0] r_next  [NUM_STATES];
    logic                     r_valid;

    // Floor shift, then clip when the upper bits are not all sign
    always_comb begin
        for (int s = 0; s < NUM_STATES; s++) begin
            w_shift[s] = i_acc[s] >>> FRAC_BITS;
            if ((&w_shift[s][ACC_W-1:DATA_W-1]) || !(|w_shift[s][ACC_W-1:DATA_W-1])) begin
                n_next[s] = w_shift[s][DATA_W-1:0];
            end else if (w_shift[s][ACC_W-1]) begin
                n_next[s] = SAT_MIN;
            end else begin
                n_next[s] = SAT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_done[0]) begin
            r_next <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_done[0];
        end
    end

    assign o_next  = r_next;
    assign o_valid = r_valid;

endmodule

@@ src/state_space_filter_step.sv @@
// ----------------------------------------------------------------------------
// state_space_filter_step: discrete state-space filter x = F*x + G*u
// Q16.16 coefficient store, optional input clamping, one state lane each.
//
// A load beat writes one F or G coefficient and returns the unchanged state
// once the output register is free. A step beat clamps the inputs (when
// enabled), then each of the NUM_STATES lanes runs its own multiply-accumulate
// over its row of NUM_STATES + NUM_INPUTS coefficients, one term per cycle;
// the single multiplier in each lane steps through its row, one bank read per
// term, and the sum then passes the multiply, accumulate, merge, state and
// output registers before the result beat appears. One beat is worked on at
// a time, so the input side is held until the result is written to the
// output register; a stalled output side adds its stall. A new beat is taken
// while the previous result still waits on the output register.
// ----------------------------------------------------------------------------
module state_space_filter_step #(
    parameter int NUM_STATES = 4,
    parameter int NUM_INPUTS = 2,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes
    input  logic                                i_cfg_we,
    input  logic [ssf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssf_pkg::DATA_W-1:0]          i_cfg_data,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: coef_index[4:0], coef_value[36:5], drive_a[68:37],
    //        drive_b[100:69], zero pad[103:101]
    input  logic [ssf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: command (0 load, 1 step)
    input  logic                                s_axis_tuser,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: state_0[31:0], state_1[63:32], state_2[95:64], state_3[127:96],
    //        clamped_flag[128], zero pad[135:129]
    output logic [ssf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import ssf_pkg::*;

    localparam int TERMS  = NUM_STATES + NUM_INPUTS;
    localparam int TERM_W = $clog2(TERMS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_POST  = 2'd3;

    // Configuration registers
    logic                     r_clamp_en;
    logic signed [DATA_W-1:0] r_low  [MAX_INPUTS];
    logic signed [DATA_W-1:0] r_high [MAX_INPUTS];

    // Filter state
    logic signed [DATA_W-1:0] r_state [NUM_STATES];
    logic signed [DATA_W-1:0] r_u     [NUM_INPUTS];
    logic signed [DATA_W-1:0] n_u     [NUM_INPUTS];
    logic                     r_clamp_seen;
    logic                     n_clamp_hit;

    // Sequencer
    logic [1:0]        r_fsm;
    logic [1:0]        n_fsm;
    logic [TERM_W-1:0] r_term;

    // Output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;
    logic                   w_out_free;

    // Input fields
    logic                     w_accept;
    logic [CIDX_W-1:0]        w_cidx;
    logic [DATA_W-1:0]        w_cval;
    logic signed [DATA_W-1:0] w_drive [MAX_INPUTS];

    // Lane wiring
    t_lane_ctl                w_ctl;
    t_bank_wr                 w_wr;
    logic                     w_wr_ok;
    logic [1:0]               w_wr_lane;
    logic [NUM_STATES-1:0]    w_wr_en;
    logic signed [DATA_W-1:0] w_opnd;
    logic signed [ACC_W-1:0]  w_acc  [NUM_STATES];
    logic [NUM_STATES-1:0]    w_done;
    logic signed [DATA_W-1:0] w_next [NUM_STATES];
    logic                     w_mrg_valid;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_cidx     = s_axis_tdata[CIDX_W-1:0];
    assign w_cval     = s_axis_tdata[CIDX_W +: DATA_W];
    assign w_drive[0] = signed'(s_axis_tdata[CIDX_W + DATA_W +: DATA_W]);
    assign w_drive[1] = signed'(s_axis_tdata[CIDX_W + 2*DATA_W +: DATA_W]);
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_en <= 1'b0;
            r_low[0]   <= '0;
            r_high[0]  <= '0;
            r_low[1]   <= '0;
            r_high[1]  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CLAMP_EN: r_clamp_en <= i_cfg_data[0];
                REG_LOW_A:    r_low[0]   <= signed'(i_cfg_data);
                REG_HIGH_A:   r_high[0]  <= signed'(i_cfg_data);
                REG_LOW_B:    r_low[1]   <= signed'(i_cfg_data);
                REG_HIGH_B:   r_high[1]  <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Clamp inputs: raise to low, then lower to high
    always_comb begin
        n_clamp_hit = 1'b0;
        for (int j = 0; j < NUM_INPUTS; j++) begin
            n_u[j] = w_drive[j];
            if (r_clamp_en) begin
                if (n_u[j] < r_low[j]) begin
                    n_u[j]      = r_low[j];
                    n_clamp_hit = 1'b1;
                end
                if (n_u[j] > r_high[j]) begin
                    n_u[j]      = r_high[j];
                    n_clamp_hit = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser == CMD_STEP) begin
            r_u <= n_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_seen <= 1'b0;
        end else if (w_accept && s_axis_tuser == CMD_STEP && n_clamp_hit) begin
            r_clamp_seen <= 1'b1;
        end
    end

    // Decode a load into lane and bank address; drop unused slots
    always_comb begin
        w_wr.data = w_cval;
        w_wr.addr = '0;
        w_wr_lane = '0;
        w_wr_ok   = 1'b0;
        if (w_cidx < CIDX_W'(G_BASE)) begin
            w_wr_lane = w_cidx[3:2];
            w_wr.addr = TERM_AW'(w_cidx[1:0]);
            w_wr_ok   = {1'b0, w_cidx[1:0]} < 3'(NUM_STATES);
        end else if (w_cidx < CIDX_W'(COEF_DEPTH)) begin
            w_wr_lane = w_cidx[2:1];
            w_wr.addr = TERM_AW'(NUM_STATES) + TERM_AW'(w_cidx[0]);
            w_wr_ok   = {1'b0, w_cidx[0]} < 2'(NUM_INPUTS);
        end
        for (int s = 0; s < NUM_STATES; s++) begin
            w_wr_en[s] = w_accept && s_axis_tuser == CMD_LOAD && w_wr_ok
                         && w_wr_lane == 2'(s);
        end
    end

    // Term sequencer and shared operand select
    always_comb begin
        w_ctl.issue = (r_fsm == S_ISSUE);
        w_ctl.first = (r_term == '0);
        w_ctl.last  = (r_term == TERM_W'(TERMS - 1));
        w_ctl.addr  = TERM_AW'(r_term);
        w_opnd      = '0;
        for (int e = 0; e < NUM_STATES; e++) begin
            if (r_term == TERM_W'(e)) begin
                w_opnd = r_state[e];
            end
        end
        for (int j = 0; j < NUM_INPUTS; j++) begin
            if (r_term == TERM_W'(NUM_STATES + j)) begin
                w_opnd = r_u[j];
            end
        end
    end

    // Lanes, one per state element
    for (genvar g = 0; g < NUM_STATES; g++) begin : g_lane
        ssf_lane #(
            .TERMS (TERMS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr_en (w_wr_en[g]),
            .i_wr    (w_wr),
            .i_ctl   (w_ctl),
            .i_opnd  (w_opnd),
            .o_acc   (w_acc[g]),
            .o_done  (w_done[g])
        );
    end

    ssf_merge #(
        .NUM_STATES (NUM_STATES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_done  (w_done),
        .o_next  (w_next),
        .o_valid (w_mrg_valid)
    );

    // Control state machine
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: begin
                if (w_accept) begin
                    n_fsm = (s_axis_tuser == CMD_STEP) ? S_ISSUE : S_POST;
                end
            end
            S_ISSUE: begin
                if (w_ctl.last) begin
                    n_fsm = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_mrg_valid) begin
                    n_fsm = S_POST;
                end
            end
            S_POST: begin
                if (w_out_free) begin
                    n_fsm = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm  <= S_IDLE;
            r_term <= '0;
        end else begin
            r_fsm <= n_fsm;
            if (r_fsm == S_ISSUE) begin
                r_term <= w_ctl.last ? '0 : r_term + 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_fsm == S_IDLE);

    // Replace the state vector once the lanes are merged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STATES; s++) begin
                r_state[s] <= '0;
            end
        end else if (r_fsm == S_DRAIN && w_mrg_valid) begin
            r_state <= w_next;
        end
    end

    // Pack the result beat; unused state slots read as zero
    always_comb begin
        n_out_data = '0;
        for (int e = 0; e < MAX_STATES; e++) begin
            if (e < NUM_STATES) begin
                n_out_data[e*DATA_W +: DATA_W] = r_state[e];
            end
        end
        n_out_data[MAX_STATES*DATA_W] = r_clamp_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_fsm == S_POST && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_POST && w_out_free) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Merged sums only arrive while the sequencer waits for them
    a_merge_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mrg_valid |-> r_fsm == S_DRAIN)
        else $error("merge result outside drain");

    // A step beat starts issuing at the first term
    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == CMD_STEP) |=> (r_fsm == S_ISSUE && r_term == '0))
        else $error("step did not start at term zero");

    // The clamp flag is sticky
    a_clamp_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_clamp_seen) |-> r_clamp_seen)
        else $error("clamp flag cleared");

    // All lanes finish together
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done == '0 || w_done == '1)
        else $error("lanes out of step");

endmodule

@@ test/ssf_step_checker.sv @@
// ----------------------------------------------------------------------------
// ssf_step_checker: prediction and comparison for state_space_filter_step
// Mirrors configuration writes, predicts the state vector and clamp flag
// for every accepted input beat and compares each output beat, in order,
// against the oldest prediction. Reports a failure count and the number of
// results still outstanding.
// ----------------------------------------------------------------------------
module ssf_step_checker #(
    parameter int NUM_STATES = 4,
    parameter int NUM_INPUTS = 2,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ssf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ssf_pkg::DATA_W-1:0]            i_cfg_data,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // tdata: coef_index, coef_value, drive_a, drive_b, zero pad
    input  logic [ssf_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // tuser: command
    input  logic                                  s_axis_tuser,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: state_0, state_1, state_2, state_3, clamped_flag, zero pad
    input  logic [ssf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output int                                    o_mismatches,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssf_pkg::*;

    // Six full-width products plus headroom
    localparam int SUM_W    = 2 * DATA_W + 4;
    localparam int FLAG_BIT = MAX_STATES * DATA_W;
    localparam logic signed [SUM_W-1:0] POS_LIMIT = 64'sd2147483647;
    localparam logic signed [SUM_W-1:0] NEG_LIMIT = -64'sd2147483648;

    typedef struct packed {
        logic                               clamped;
        logic [MAX_STATES-1:0][DATA_W-1:0]  states;
    } t_filter_report;

    // Predicted filter state and mirrored configuration
    logic signed [DATA_W-1:0] state_vec  [MAX_STATES];
    logic signed [DATA_W-1:0] coef_mem   [COEF_DEPTH];
    logic signed [DATA_W-1:0] low_bound  [MAX_INPUTS];
    logic signed [DATA_W-1:0] high_bound [MAX_INPUTS];
    logic                     clamp_on;
    logic                     clamp_flag;

    t_filter_report expected_reports [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        clamp_on     = 1'b0;
        clamp_flag   = 1'b0;
        for (int k = 0; k < COEF_DEPTH; k++) coef_mem[k] = '0;
    end

    // Apply one beat to the predicted state and return the report it causes
    function automatic t_filter_report apply_beat(
        input logic                     cmd,
        input logic [CIDX_W-1:0]        idx,
        input logic signed [DATA_W-1:0] coef,
        input logic signed [DATA_W-1:0] drive_a,
        input logic signed [DATA_W-1:0] drive_b
    );
        logic signed [DATA_W-1:0] drive      [MAX_INPUTS];
        logic signed [DATA_W-1:0] next_state [MAX_STATES];
        logic signed [SUM_W-1:0]  acc;
        t_filter_report           rep;
        int                       i;
        int                       j;

        if (cmd == CMD_LOAD) begin
            // Indexes past the store are dropped
            if (idx < COEF_DEPTH) coef_mem[idx] = coef;
        end else begin
            drive[0] = drive_a;
            drive[1] = drive_b;
            // Raise to low, then lower to high: high wins on crossed bounds
            if (clamp_on) begin
                for (j = 0; j < NUM_INPUTS; j++) begin
                    if (drive[j] < low_bound[j]) begin
                        drive[j]   = low_bound[j];
                        clamp_flag = 1'b1;
                    end
                    if (drive[j] > high_bound[j]) begin
                        drive[j]   = high_bound[j];
                        clamp_flag = 1'b1;
                    end
                end
            end
            // Exact sum, floor shift, saturate
            for (i = 0; i < MAX_STATES; i++) begin
                next_state[i] = '0;
                if (i < NUM_STATES) begin
                    acc = '0;
                    for (j = 0; j < NUM_STATES; j++)
                        acc = acc + coef_mem[i * MAX_STATES + j] * state_vec[j];
                    for (j = 0; j < NUM_INPUTS; j++)
                        acc = acc + coef_mem[G_BASE + i * MAX_INPUTS + j] * drive[j];
                    acc = acc >>> FRAC_BITS;
                    if (acc > POS_LIMIT)
                        next_state[i] = 32'h7FFF_FFFF;
                    else if (acc < NEG_LIMIT)
                        next_state[i] = 32'h8000_0000;
                    else
                        next_state[i] = acc[DATA_W-1:0];
                end
            end
            for (i = 0; i < MAX_STATES; i++) state_vec[i] = next_state[i];
        end

        rep.clamped = clamp_flag;
        for (i = 0; i < MAX_STATES; i++) rep.states[i] = state_vec[i];
        return rep;
    endfunction

    task automatic log_failure(input string msg);
        if (o_mismatches < 10) $display("%0t ns: %s", $time, msg);
        o_mismatches++;
    endtask

    // Watch config writes and both streams on every rising edge
    always @(posedge i_clk) begin : watch
        t_filter_report    want;
        logic [DATA_W-1:0] got;
        int                k;

        if (!i_rst_n) begin
            for (k = 0; k < MAX_STATES; k++) state_vec[k] = '0;
            for (k = 0; k < MAX_INPUTS; k++) begin
                low_bound[k]  = '0;
                high_bound[k] = '0;
            end
            clamp_on   = 1'b0;
            clamp_flag = 1'b0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CLAMP_EN: clamp_on      = i_cfg_data[0];
                    REG_LOW_A:    low_bound[0]  = i_cfg_data;
                    REG_HIGH_A:   high_bound[0] = i_cfg_data;
                    REG_LOW_B:    low_bound[1]  = i_cfg_data;
                    REG_HIGH_B:   high_bound[1] = i_cfg_data;
                    default: ;
                endcase
            end

            // Compare a result beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    log_failure($sformatf("result beat with nothing outstanding: %h",
                                          m_axis_tdata));
                end else begin
                    want = expected_reports.pop_front();
                    for (k = 0; k < MAX_STATES; k++) begin
                        got = m_axis_tdata[k * DATA_W +: DATA_W];
                        if (got !== want.states[k])
                            log_failure($sformatf("state_%0d: expected %h, got %h",
                                                  k, want.states[k], got));
                    end
                    if (m_axis_tdata[FLAG_BIT] !== want.clamped)
                        log_failure($sformatf("clamped_flag: expected %0b, got %0b",
                                              want.clamped, m_axis_tdata[FLAG_BIT]));
                end
            end

            // Predict the result of an accepted input beat
            if (s_axis_tvalid && s_axis_tready)
                expected_reports.push_back(apply_beat(s_axis_tuser, s_axis_tdata[4:0],
                                                      s_axis_tdata[36:5],
                                                      s_axis_tdata[68:37],
                                                      s_axis_tdata[100:69]));
        end
        o_pending = expected_reports.size();
    end

endmodule

@@ test/state_space_filter_step_test.sv @@
// ----------------------------------------------------------------------------
// state_space_filter_step_test: stimulus and verdict for the filter step
// Loads every coefficient, runs directed steps at the field extremes and
// through the clamp cases, then random load/step traffic over several clamp
// settings with bursty input and a stalling result side. Checking is done
// by ssf_step_checker.
// ----------------------------------------------------------------------------
module state_space_filter_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssf_pkg::*;

    localparam int N_STATES    = 4;
    localparam int N_INPUTS    = 2;
    localparam int N_FRAC      = 16;
    localparam int PHASE_BEATS = 235;
    localparam int COEF_SPAN   = 32'h3000;
    localparam int DRIVE_SPAN  = 32'h4_0000;
    localparam int BOUND_SPAN  = 32'h3_0000;
    localparam int TIMEOUT_NS  = 10_000_000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [DATA_W-1:0]       i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    int                      mismatches;
    int                      pending;
    int                      stall_mode = 0;
    int                      stall_left = 0;

    state_space_filter_step #(
        .NUM_STATES (N_STATES),
        .NUM_INPUTS (N_INPUTS),
        .FRAC_BITS  (N_FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ssf_step_checker #(
        .NUM_STATES (N_STATES),
        .NUM_INPUTS (N_INPUTS),
        .FRAC_BITS  (N_FRAC)
    ) filter_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: switch between stall patterns, each held for a random stretch
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 160);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_left[1:0] != 2'd0);
        endcase
    end

    // Mostly values near zero, now and then full range or an extreme
    function automatic logic [DATA_W-1:0] pick_value(input int unsigned span,
                                                     input int unsigned odds);
        int unsigned r;
        r = $urandom_range(0, odds - 1);
        case (r)
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // Present one beat and hold it until accepted
    task automatic send_beat(input logic cmd, input logic [CIDX_W-1:0] idx,
                             input logic [DATA_W-1:0] coef,
                             input logic [DATA_W-1:0] drive_a,
                             input logic [DATA_W-1:0] drive_b);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, drive_b, drive_a, coef, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic pause(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // Drop valid and wait for every predicted result to come back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Write all clamp registers, plus one write to an unmapped index
    task automatic program_bounds(input logic en,
                                  input logic [DATA_W-1:0] lo_a,
                                  input logic [DATA_W-1:0] hi_a,
                                  input logic [DATA_W-1:0] lo_b,
                                  input logic [DATA_W-1:0] hi_b);
        cfg_write(REG_CLAMP_EN, {31'($urandom), en});
        cfg_write(REG_LOW_A, lo_a);
        cfg_write(REG_HIGH_A, hi_a);
        cfg_write(REG_LOW_B, lo_b);
        cfg_write(REG_HIGH_B, hi_b);
        cfg_write(CFG_IDX_W'($urandom_range(5, 7)), $urandom);
    endtask

    // Random loads and steps in bursts with gaps
    task automatic run_random(input int beats);
        int                  burst;
        int                  n;
        logic [CIDX_W-1:0]   idx;
        burst = 0;
        for (n = 0; n < beats; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
            end
            burst--;
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 15) == 0)
                    idx = CIDX_W'($urandom_range(COEF_DEPTH, 31));
                else
                    idx = CIDX_W'($urandom_range(0, COEF_DEPTH - 1));
                send_beat(CMD_LOAD, idx, pick_value(COEF_SPAN, 48), $urandom, $urandom);
            end else begin
                send_beat(CMD_STEP, CIDX_W'($urandom), $urandom,
                          pick_value(DRIVE_SPAN, 8), pick_value(DRIVE_SPAN, 8));
            end
        end
        drain();
    endtask

    initial begin
        #TIMEOUT_NS;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [DATA_W-1:0] coef;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        int                k;
        int                ph;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole store before the first step, extremes on a few taps
        for (k = 0; k < COEF_DEPTH; k++) begin
            case (k)
                0, 16:   coef = 32'h7FFF_FFFF;
                5, 19:   coef = 32'h8000_0000;
                10, 20:  coef = 32'h0001_0000;
                15:      coef = 32'hFFFF_8000;
                21:      coef = 32'hFFFF_0000;
                22:      coef = 32'h0000_8000;
                default: coef = $urandom_range(0, 32'h2000) - 32'h1000;
            endcase
            send_beat(CMD_LOAD, CIDX_W'(k), coef, $urandom, $urandom);
        end

        // Extreme drives with clamping off: saturation both ways
        send_beat(CMD_STEP, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(CMD_STEP, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(CMD_STEP, '0, '0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_STEP, '1, '1, 32'hFFFF_FFFF, 32'h0000_0001);

        // Loads past the store are dropped; the step shows nothing changed
        send_beat(CMD_LOAD, CIDX_W'(COEF_DEPTH), 32'h7FFF_FFFF, '1, '1);
        send_beat(CMD_LOAD, '1, 32'h8000_0000, '0, '0);
        send_beat(CMD_STEP, '0, '0, 32'h0001_0000, 32'hFFFF_0000);
        drain();

        // Crossed bounds on input a, narrow window on input b
        program_bounds(1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_8000, 32'h0000_8000);
        send_beat(CMD_STEP, '0, '0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_STEP, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(CMD_STEP, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        // Random traffic over a sweep of clamp settings
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: program_bounds(1'b0, $urandom, $urandom, $urandom, $urandom);
                1: program_bounds(1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF);
                2: begin
                    lo = -$urandom_range(0, BOUND_SPAN);
                    hi = $urandom_range(0, BOUND_SPAN);
                    program_bounds(1'b1, lo, hi, -$urandom_range(0, BOUND_SPAN),
                                   $urandom_range(0, BOUND_SPAN));
                end
                3: begin
                    lo = $urandom_range(1, BOUND_SPAN);
                    hi = -$urandom_range(1, BOUND_SPAN);
                    program_bounds(1'b1, lo, hi, hi, lo);
                end
                4: begin
                    lo = $urandom_range(0, 2 * BOUND_SPAN) - BOUND_SPAN;
                    hi = $urandom_range(0, 2 * BOUND_SPAN) - BOUND_SPAN;
                    program_bounds(1'b1, lo, lo, hi, hi);
                end
                default: program_bounds(1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h8000_0000);
            endcase
            run_random(PHASE_BEATS);
        end

        drain();
        repeat (30) @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
